FILE: hdl/btc_pkg.sv
package btc_pkg;

  localparam int CURVE_POINTS_DEF = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Input item kinds
  localparam logic [2:0] KIND_TICK        = 3'd0;
  localparam logic [2:0] KIND_ZERO_CROSS  = 3'd1;
  localparam logic [2:0] KIND_TIMEOUT     = 3'd2;
  localparam logic [2:0] KIND_SWITCH      = 3'd3;
  localparam logic [2:0] KIND_CLOSE       = 3'd4;
  localparam logic [2:0] KIND_OPEN        = 3'd5;
  localparam logic [2:0] KIND_WRITE_POINT = 3'd6;

  // Breaker phases
  localparam logic [2:0] PH_OPENED  = 3'd1;
  localparam logic [2:0] PH_CLOSING = 3'd2;
  localparam logic [2:0] PH_CLOSED  = 3'd3;
  localparam logic [2:0] PH_OPENING = 3'd4;

  // Trip causes
  localparam logic [2:0] CA_EXT      = 3'd1;
  localparam logic [2:0] CA_OCP_HW   = 3'd2;
  localparam logic [2:0] CA_OCP_SW   = 3'd3;
  localparam logic [2:0] CA_OTP      = 3'd4;
  localparam logic [2:0] CA_OCP_TEST = 3'd5;
  localparam logic [2:0] CA_UVP      = 3'd6;

  // Switch open causes
  localparam logic [2:0] SC_OCP      = 3'd1;
  localparam logic [2:0] SC_OTP      = 3'd2;
  localparam logic [2:0] SC_OCP_TEST = 3'd3;
  localparam logic [2:0] SC_UVP      = 3'd4;

  // Switch commands
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WALK,
    ST_FINISH
  } btc_state_t;

  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic exec;
    logic step;
    logic load_out;
  } btc_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] kind;
    logic       tick_go;
    logic       first;
    logic       below0;
    logic       last;
    logic       out_free;
  } btc_sts_t;

  function automatic logic [1:0] commit_cmd(input logic [2:0] phase);
    logic [1:0] c;
    c = CMD_NONE;
    if (phase == PH_CLOSING) c = CMD_ON;
    else if (phase == PH_OPENING) c = CMD_OFF;
    return c;
  endfunction

  function automatic logic [2:0] map_cause(input logic [2:0] cur, input logic [2:0] sc);
    logic [2:0] c;
    unique case (sc)
      SC_OCP:      c = CA_OCP_HW;
      SC_OTP:      c = CA_OTP;
      SC_OCP_TEST: c = CA_OCP_TEST;
      SC_UVP:      c = CA_UVP;
      default:     c = (cur == CA_OCP_SW) ? CA_OCP_SW : CA_EXT;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/btc_channels.sv
interface btc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] current_amps;
  logic        switch_closed;
  logic [2:0]  switch_cause;
  logic [3:0]  point_index;
  logic [15:0] point_current;
  logic [15:0] point_duration;

  modport source (output valid, kind, current_amps, switch_closed, switch_cause,
                  point_index, point_current, point_duration, input ready);
  modport sink (input valid, kind, current_amps, switch_closed, switch_cause,
                point_index, point_current, point_duration, output ready);
endinterface

interface btc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  switch_command;
  logic        trip_notify;
  logic [2:0]  breaker_state;
  logic [2:0]  trip_cause;
  logic [15:0] retries_remaining;

  modport source (output valid, switch_command, trip_notify, breaker_state, trip_cause,
                  retries_remaining, input ready);
  modport sink (input valid, switch_command, trip_notify, breaker_state, trip_cause,
                retries_remaining, output ready);
endinterface

interface btc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [15:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

FILE: hdl/btc_ctrl.sv
module btc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  btc_pkg::btc_sts_t sts,
  output btc_pkg::btc_cmd_t cmd
);
  import btc_pkg::*;

  btc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        // A tick that can count starts the walk; the read of point 0 is in flight.
        if (sts.kind == KIND_TICK && sts.tick_go) begin
          state_nxt = ST_WALK;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_WALK: begin
        // Current below the first point leaves every counter untouched.
        if (sts.first && sts.below0) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
          if (sts.last) state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && sts.in_valid) |=> (state_r == ST_DISPATCH))
    else $error("accepted item did not reach dispatch");

  a_walk_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (sts.kind == KIND_TICK && sts.tick_go))
    else $error("curve walk without an armed tick");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && sts.out_free) |=> (state_r == ST_IDLE))
    else $error("finished item did not release the controller");

endmodule

FILE: hdl/btc_datapath.sv
module btc_datapath #(
  parameter int CURVE_POINTS = btc_pkg::CURVE_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  btc_in_if.sink            in_ch,
  btc_out_if.source         out_ch,
  btc_cfg_if.sink           cfg_ch,
  input  btc_pkg::btc_cmd_t cmd,
  output btc_pkg::btc_sts_t sts
);
  import btc_pkg::*;

  localparam int IW  = (CURVE_POINTS > 1) ? $clog2(CURVE_POINTS) : 1;
  localparam int NW0 = $clog2(CURVE_POINTS + 1);
  localparam int NW  = (NW0 > 5) ? NW0 : 5;

  // Configuration
  logic [15:0] recovery_r;
  logic [4:0]  point_count_r;

  // Latched input item
  logic [2:0]  kind_r;
  logic [15:0] amps_r;
  logic        sw_closed_r;
  logic [2:0]  sw_cause_r;
  logic [3:0]  pidx_r;
  logic [15:0] pcur_r;
  logic [15:0] pdur_r;

  // Breaker state
  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  cause_r, cause_nxt;
  logic [15:0] retries_r, retries_nxt;
  logic        armed_r, armed_nxt;
  logic        pending_r, pending_nxt;
  logic [1:0]  swcmd_r, swcmd_nxt;
  logic        notify_r, notify_nxt;

  // Curve walk
  logic [IW-1:0] wi_r;
  logic [IW-1:0] rd_addr;
  logic          trip_r;
  logic [NW-1:0] n_pts;

  logic [15:0] thr_mem  [CURVE_POINTS];
  logic [15:0] dur_mem  [CURVE_POINTS];
  logic [15:0] hold_mem [CURVE_POINTS];
  logic [CURVE_POINTS-1:0] tbl_vld_r;
  logic [CURVE_POINTS-1:0] hold_vld_r;
  logic [15:0] thr_q_r, dur_q_r, hold_q_r;
  logic        tv_q_r, hv_q_r;

  logic [15:0] thr_eff, dur_eff, hold_cur, hold_new;
  logic        step_trip, trip_any, tbl_we, hold_clr;
  logic [IW-1:0] wr_idx;
  logic [2:0]  cause_mapped;

  // Output register
  logic        out_valid_r;
  logic [1:0]  o_cmd_r;
  logic        o_notify_r;
  logic [2:0]  o_state_r;
  logic [2:0]  o_cause_r;
  logic [15:0] o_retries_r;

  assign in_ch.ready  = cmd.in_ready;
  assign cfg_ch.ready = 1'b1;

  assign n_pts = (int'(point_count_r) > CURVE_POINTS) ? NW'(CURVE_POINTS) : NW'(point_count_r);

  assign rd_addr = cmd.step ? wi_r + IW'(1) : wi_r;
  assign wr_idx  = IW'(pidx_r);
  assign tbl_we  = cmd.exec && kind_r == KIND_WRITE_POINT && int'(pidx_r) < CURVE_POINTS;
  assign hold_clr = cmd.exec && kind_r == KIND_CLOSE && phase_r != PH_CLOSED;

  // Entries never written read as zero.
  assign thr_eff  = tv_q_r ? thr_q_r : 16'd0;
  assign dur_eff  = tv_q_r ? dur_q_r : 16'd0;
  assign hold_cur = hv_q_r ? hold_q_r : 16'd0;
  assign hold_new = (amps_r >= thr_eff) ? ((hold_cur == 16'hFFFF) ? hold_cur : hold_cur + 16'd1)
                                        : 16'd0;
  assign step_trip = hold_new >= dur_eff;
  assign trip_any  = trip_r | step_trip;

  assign sts.in_valid = in_ch.valid;
  assign sts.kind     = kind_r;
  assign sts.tick_go  = armed_r && n_pts != '0;
  assign sts.first    = wi_r == '0;
  assign sts.below0   = amps_r < thr_eff;
  assign sts.last     = (NW'(wi_r) + NW'(1)) == n_pts;
  assign sts.out_free = !out_valid_r || out_ch.ready;

  assign cause_mapped = map_cause(cause_r, sw_cause_r);

  always_comb begin
    phase_nxt   = phase_r;
    cause_nxt   = cause_r;
    retries_nxt = retries_r;
    armed_nxt   = armed_r;
    pending_nxt = pending_r;
    swcmd_nxt   = swcmd_r;
    notify_nxt  = notify_r;
    if (cmd.load_in) begin
      swcmd_nxt  = CMD_NONE;
      notify_nxt = 1'b0;
    end
    if (cmd.exec) begin
      unique case (kind_r)
        KIND_ZERO_CROSS: begin
          pending_nxt = 1'b0;
          swcmd_nxt   = commit_cmd(phase_r);
        end
        KIND_TIMEOUT: begin
          if (pending_r) begin
            pending_nxt = 1'b0;
            swcmd_nxt   = commit_cmd(phase_r);
          end
        end
        KIND_SWITCH: begin
          pending_nxt = 1'b0;
          if (sw_closed_r) begin
            phase_nxt = PH_CLOSED;
            cause_nxt = CA_EXT;
          end else begin
            phase_nxt = PH_OPENED;
            cause_nxt = cause_mapped;
            if (cause_mapped == CA_OCP_SW) begin
              notify_nxt = 1'b1;
            end else if (cause_mapped == CA_OCP_HW) begin
              // Hardware overcurrent re-closes while retries remain.
              if (retries_r == '0) begin
                notify_nxt = 1'b1;
              end else begin
                retries_nxt = retries_r - 16'd1;
                phase_nxt   = PH_CLOSING;
                pending_nxt = 1'b1;
              end
            end
          end
        end
        KIND_CLOSE: begin
          if (phase_r != PH_CLOSED) begin
            retries_nxt = recovery_r;
            phase_nxt   = PH_CLOSING;
            cause_nxt   = CA_EXT;
            pending_nxt = 1'b1;
            armed_nxt   = 1'b1;
          end
        end
        KIND_OPEN: begin
          if (phase_r != PH_OPENED) begin
            retries_nxt = '0;
            phase_nxt   = PH_OPENING;
            cause_nxt   = CA_EXT;
            pending_nxt = 1'b1;
            armed_nxt   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.step && sts.last && trip_any) begin
      retries_nxt = '0;
      phase_nxt   = PH_OPENING;
      cause_nxt   = CA_OCP_SW;
      pending_nxt = 1'b1;
      armed_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recovery_r    <= '0;
      point_count_r <= '0;
      phase_r       <= PH_OPENED;
      cause_r       <= CA_EXT;
      retries_r     <= '0;
      armed_r       <= 1'b1;
      pending_r     <= 1'b1;
      swcmd_r       <= CMD_NONE;
      notify_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      tbl_vld_r     <= '0;
      hold_vld_r    <= '0;
      wi_r          <= '0;
      trip_r        <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.reg_index == REG_RECOVERY) recovery_r <= cfg_ch.data;
        else if (cfg_ch.reg_index == REG_POINT_COUNT) point_count_r <= cfg_ch.data[4:0];
      end
      phase_r   <= phase_nxt;
      cause_r   <= cause_nxt;
      retries_r <= retries_nxt;
      armed_r   <= armed_nxt;
      pending_r <= pending_nxt;
      swcmd_r   <= swcmd_nxt;
      notify_r  <= notify_nxt;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (tbl_we) tbl_vld_r[wr_idx] <= 1'b1;
      if (hold_clr) hold_vld_r <= '0;
      else if (cmd.step) hold_vld_r[wi_r] <= 1'b1;
      if (cmd.load_in) begin
        wi_r   <= '0;
        trip_r <= 1'b0;
      end else if (cmd.step) begin
        wi_r   <= wi_r + IW'(1);
        trip_r <= trip_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r      <= in_ch.kind;
      amps_r      <= in_ch.current_amps;
      sw_closed_r <= in_ch.switch_closed;
      sw_cause_r  <= in_ch.switch_cause;
      pidx_r      <= in_ch.point_index;
      pcur_r      <= in_ch.point_current;
      pdur_r      <= in_ch.point_duration;
    end
    if (cmd.load_out) begin
      o_cmd_r     <= swcmd_r;
      o_notify_r  <= notify_r;
      o_state_r   <= phase_r;
      o_cause_r   <= cause_r;
      o_retries_r <= retries_r;
    end
  end

  // Curve memories, one point read per cycle.
  always_ff @(posedge clk) begin
    thr_q_r  <= thr_mem[rd_addr];
    dur_q_r  <= dur_mem[rd_addr];
    hold_q_r <= hold_mem[rd_addr];
    tv_q_r   <= tbl_vld_r[rd_addr];
    hv_q_r   <= hold_vld_r[rd_addr];
    if (tbl_we) begin
      thr_mem[wr_idx] <= pcur_r;
      dur_mem[wr_idx] <= pdur_r;
    end
    if (cmd.step) hold_mem[wi_r] <= hold_new;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.switch_command    = o_cmd_r;
  assign out_ch.trip_notify       = o_notify_r;
  assign out_ch.breaker_state     = o_state_r;
  assign out_ch.trip_cause        = o_cause_r;
  assign out_ch.retries_remaining = o_retries_r;

  a_trip_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.last && trip_any) |=>
      (!armed_r && phase_r == PH_OPENING && cause_r == CA_OCP_SW && retries_r == '0))
    else $error("curve trip not applied");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (NW'(wi_r) < n_pts))
    else $error("curve walk beyond points in use");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result register not loaded");

endmodule

FILE: hdl/breaker_trip_curve_controller_core.sv
// Channel  Direction  Fields
// in_ch    sink       kind, current_amps, switch_closed, switch_cause, point_index,
//                     point_current, point_duration
// out_ch   source     switch_command, trip_notify, breaker_state, trip_cause,
//                     retries_remaining
// cfg_ch   sink       reg_index, data (0 retry_budget, 1 point_count)
//
// An accepted item goes through the dispatch state, then the finish state, to the load of
// the result register; a tick that walks the curve passes through the walk state between
// them, also when its current lies below the first point. The next item can be accepted the cycle after.
// The tick time is set by the curve walk, one point per cycle through the curve memories.
// Reset is synchronous and clears configuration, breaker state and the curve valid bits.
// The result register lets the next item be accepted while a result waits; a new result
// waits in the controller until the register is free.
module breaker_trip_curve_controller_core #(
  parameter int CURVE_POINTS = btc_pkg::CURVE_POINTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  btc_in_if.sink    in_ch,
  btc_out_if.source out_ch,
  btc_cfg_if.sink   cfg_ch
);
  import btc_pkg::*;

  btc_cmd_t cmd;
  btc_sts_t sts;

  btc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  btc_datapath #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

FILE: tb/tb_breaker_trip_curve_controller_core.sv
`timescale 1ns / 1ps

module tb_breaker_trip_curve_controller_core;
  import btc_pkg::*;

  localparam int CURVE_POINTS = CURVE_POINTS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam logic [2:0] SC_OTHER = 3'd0;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] amps;
    logic        closed;
    logic [2:0]  cause;
    logic [3:0]  idx;
    logic [15:0] thr;
    logic [15:0] dur;
  } breaker_event_t;

  typedef struct {
    logic [1:0]  cmd;
    logic        notify;
    logic [2:0]  phase;
    logic [2:0]  cause;
    logic [15:0] retries;
  } breaker_report_t;

  logic clk;
  logic rst_n;

  btc_in_if  in_ch();
  btc_out_if out_ch();
  btc_cfg_if cfg_ch();

  breaker_trip_curve_controller_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Breaker state as the block should hold it, updated at each accepted item.
  logic [15:0] cfg_recovery;
  logic [4:0]  cfg_points;
  logic [2:0]  model_phase;
  logic [2:0]  model_cause;
  logic [15:0] model_retries;
  logic [15:0] hold_cnt[CURVE_POINTS];
  logic [15:0] thr_tab[CURVE_POINTS];
  logic [15:0] dur_tab[CURVE_POINTS];
  bit          armed;
  bit          commit_due;

  breaker_report_t due_reports[$];
  int failures = 0;
  int items_sent = 0;
  int cycle_count = 0;
  bit steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_breaker_trip_curve_controller_core NOT OK");
      $finish;
    end
  end

  task automatic step_breaker(input breaker_event_t ev, output breaker_report_t rep);
    int n;
    bit trip;
    rep.cmd = CMD_NONE;
    rep.notify = 1'b0;
    case (ev.kind)
      KIND_TICK: begin
        n = (cfg_points > CURVE_POINTS) ? CURVE_POINTS : int'(cfg_points);
        if (armed && n != 0 && ev.amps >= thr_tab[0]) begin
          trip = 1'b0;
          for (int i = 0; i < n; i++) begin
            if (ev.amps >= thr_tab[i]) begin
              if (hold_cnt[i] != 16'hFFFF) hold_cnt[i] = hold_cnt[i] + 16'd1;
            end else begin
              hold_cnt[i] = 16'd0;
            end
            if (hold_cnt[i] >= dur_tab[i]) trip = 1'b1;
          end
          if (trip) begin
            model_retries = 16'd0;
            model_phase = PH_OPENING;
            model_cause = CA_OCP_SW;
            commit_due = 1'b1;
            armed = 1'b0;
          end
        end
      end
      KIND_ZERO_CROSS, KIND_TIMEOUT: begin
        // A zero cross always commits; a timeout only when a commit is due.
        if (ev.kind == KIND_ZERO_CROSS || commit_due) begin
          commit_due = 1'b0;
          if (model_phase == PH_CLOSING) rep.cmd = CMD_ON;
          else if (model_phase == PH_OPENING) rep.cmd = CMD_OFF;
        end
      end
      KIND_SWITCH: begin
        commit_due = 1'b0;
        if (ev.closed) begin
          model_phase = PH_CLOSED;
          model_cause = CA_EXT;
        end else begin
          model_phase = PH_OPENED;
          case (ev.cause)
            SC_OCP:      model_cause = CA_OCP_HW;
            SC_OTP:      model_cause = CA_OTP;
            SC_OCP_TEST: model_cause = CA_OCP_TEST;
            SC_UVP:      model_cause = CA_UVP;
            default:     if (model_cause != CA_OCP_SW) model_cause = CA_EXT;
          endcase
          if (model_cause == CA_OCP_SW) begin
            rep.notify = 1'b1;
          end else if (model_cause == CA_OCP_HW) begin
            if (model_retries == 16'd0) begin
              rep.notify = 1'b1;
            end else begin
              model_retries = model_retries - 16'd1;
              model_phase = PH_CLOSING;
              commit_due = 1'b1;
            end
          end
        end
      end
      KIND_CLOSE: begin
        if (model_phase != PH_CLOSED) begin
          foreach (hold_cnt[i]) hold_cnt[i] = 16'd0;
          model_retries = cfg_recovery;
          model_phase = PH_CLOSING;
          model_cause = CA_EXT;
          commit_due = 1'b1;
          armed = 1'b1;
        end
      end
      KIND_OPEN: begin
        if (model_phase != PH_OPENED) begin
          model_retries = 16'd0;
          model_phase = PH_OPENING;
          model_cause = CA_EXT;
          commit_due = 1'b1;
          armed = 1'b0;
        end
      end
      KIND_WRITE_POINT: begin
        thr_tab[ev.idx] = ev.thr;
        dur_tab[ev.idx] = ev.dur;
      end
      default: ;
    endcase
    rep.phase = model_phase;
    rep.cause = model_cause;
    rep.retries = model_retries;
  endtask

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : report_check
    breaker_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_reports.size() == 0) begin
        $display("%0t unexpected result: expected none actual state %0d cause %0d", $time,
                 out_ch.breaker_state, out_ch.trip_cause);
        failures++;
      end else begin
        want = due_reports.pop_front();
        compare_field("switch_command", 16'(want.cmd), 16'(out_ch.switch_command));
        compare_field("trip_notify", 16'(want.notify), 16'(out_ch.trip_notify));
        compare_field("breaker_state", 16'(want.phase), 16'(out_ch.breaker_state));
        compare_field("trip_cause", 16'(want.cause), 16'(out_ch.trip_cause));
        compare_field("retries_remaining", want.retries, out_ch.retries_remaining);
      end
    end
    out_ch.ready <= steady || ($urandom_range(99) >= 18);
  end

  function automatic breaker_event_t random_event(input logic [2:0] kind);
    breaker_event_t ev;
    ev.kind = kind;
    ev.amps = 16'($urandom_range(65535));
    ev.closed = 1'($urandom_range(1));
    ev.cause = 3'($urandom_range(7));
    ev.idx = 4'($urandom_range(15));
    ev.thr = 16'($urandom_range(65535));
    ev.dur = 16'($urandom_range(65535));
    return ev;
  endfunction

  task automatic send_item(input breaker_event_t ev);
    breaker_report_t rep;
    if (!steady && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= ev.kind;
    in_ch.current_amps <= ev.amps;
    in_ch.switch_closed <= ev.closed;
    in_ch.switch_cause <= ev.cause;
    in_ch.point_index <= ev.idx;
    in_ch.point_current <= ev.thr;
    in_ch.point_duration <= ev.dur;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    step_breaker(ev, rep);
    due_reports.push_back(rep);
    items_sent++;
  endtask

  task automatic send_kind(input logic [2:0] kind);
    send_item(random_event(kind));
  endtask

  task automatic send_tick(input logic [15:0] amps);
    breaker_event_t ev;
    ev = random_event(KIND_TICK);
    ev.amps = amps;
    send_item(ev);
  endtask

  task automatic send_switch(input logic closed, input logic [2:0] cause);
    breaker_event_t ev;
    ev = random_event(KIND_SWITCH);
    ev.closed = closed;
    ev.cause = cause;
    send_item(ev);
  endtask

  task automatic send_point(input logic [3:0] idx, input logic [15:0] thr,
                            input logic [15:0] dur);
    breaker_event_t ev;
    ev = random_event(KIND_WRITE_POINT);
    ev.idx = idx;
    ev.thr = thr;
    ev.dur = dur;
    send_item(ev);
  endtask

  task automatic send_commit();
    send_kind(($urandom_range(3) == 0) ? KIND_TIMEOUT : KIND_ZERO_CROSS);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] recovery, input logic [4:0] points);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= REG_RECOVERY;
    cfg_ch.data <= recovery;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_recovery = recovery;
    cfg_ch.reg_index <= REG_POINT_COUNT;
    cfg_ch.data <= {11'd0, points};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_points = points;
    cfg_ch.valid <= 1'b0;
  endtask

  // Rising thresholds with short hold times, now and then a zero duration.
  task automatic load_curve(input int step_max);
    int level;
    level = $urandom_range(300);
    for (int i = 0; i < CURVE_POINTS; i++) begin
      send_point(4'(i), 16'(level),
                 ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 12)));
      level = level + $urandom_range(1, step_max);
      if (level > 65535) level = 65535;
    end
  endtask

  function automatic logic [15:0] pick_current();
    int a;
    int off;
    off = $urandom_range(2);
    case ($urandom_range(5))
      0: a = $urandom_range(65535);
      1: a = int'(thr_tab[0]) - 1;
      default: a = int'(thr_tab[$urandom_range(15)]) + off - 1;
    endcase
    if (a < 0) a = 0;
    if (a > 65535) a = 65535;
    return 16'(a);
  endfunction

  // Close, commit, run on the curve, then leave by a trip, a command or a switch fault.
  task automatic run_breaker_cycle(input int step_max);
    int rounds;
    int ticks;
    rounds = 0;
    if ($urandom_range(14) == 0) load_curve(step_max);
    send_kind(KIND_CLOSE);
    while (model_phase == PH_CLOSING && rounds < 6) begin
      rounds++;
      send_commit();
      if ($urandom_range(3) == 0) begin
        send_switch(1'b0, SC_OCP);
      end else begin
        send_switch(1'b1, 3'($urandom_range(7)));
        ticks = $urandom_range(1, 14);
        while (ticks > 0 && model_phase == PH_CLOSED) begin
          send_tick(pick_current());
          ticks--;
        end
        if (model_phase == PH_CLOSED) begin
          case ($urandom_range(2))
            0: send_switch(1'b0, SC_OCP);
            1: begin
              send_kind(KIND_OPEN);
              send_commit();
              send_switch(1'b0, 3'($urandom_range(7)));
            end
            default: send_switch(1'b0, 3'($urandom_range(7)));
          endcase
        end else begin
          send_commit();
          send_switch(1'b0, ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : SC_OTHER);
        end
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] recovery, input logic [4:0] points,
                           input int step_max, input bit steady_run, input int budget);
    int start;
    hold_until_drained();
    write_config(recovery, points);
    steady = steady_run;
    start = items_sent;
    load_curve(step_max);
    while (items_sent - start < budget) begin
      if ($urandom_range(4) == 0) send_item(random_event(3'($urandom_range(7))));
      else run_breaker_cycle(step_max);
    end
    steady = 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_tick(16'hFFFF);
    send_kind(KIND_TIMEOUT);
    send_kind(KIND_TIMEOUT);
    send_kind(KIND_OPEN);
    send_kind(KIND_UNUSED);
  endtask

  task automatic test_curve_trip();
    hold_until_drained();
    write_config(16'd1, 5'd2);
    send_point(4'd0, 16'd100, 16'd3);
    send_point(4'd1, 16'd1000, 16'd2);
    send_point(4'd15, 16'hFFFF, 16'hFFFF);
    send_kind(KIND_CLOSE);
    send_kind(KIND_ZERO_CROSS);
    send_switch(1'b1, SC_OTHER);
    send_tick(16'd99);
    send_tick(16'd500);
    send_tick(16'd1000);
    send_tick(16'd1000);
    // The monitor is disarmed after the trip, so this one is ignored.
    send_tick(16'hFFFF);
    send_kind(KIND_ZERO_CROSS);
    send_switch(1'b0, SC_OTHER);
  endtask

  task automatic test_hw_overcurrent_retry();
    send_kind(KIND_CLOSE);
    send_kind(KIND_TIMEOUT);
    send_switch(1'b1, 3'd7);
    send_kind(KIND_CLOSE);
    send_switch(1'b0, SC_OCP);
    send_kind(KIND_ZERO_CROSS);
    send_switch(1'b0, SC_OCP);
  endtask

  task automatic test_random_traffic();
    run_phase(16'd0, 5'd0, 400, 1'b0, 140);
    run_phase(16'hFFFF, 5'd16, 5000, 1'b1, 150);
    run_phase(16'd1, 5'd1, 300, 1'b0, 140);
    run_phase(16'd3, 5'd31, 200, 1'b0, 140);
    run_phase(16'($urandom_range(2, 6)), 5'($urandom_range(2, 15)), 600, 1'b0, 150);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_TICK;
    in_ch.current_amps <= 16'd0;
    in_ch.switch_closed <= 1'b0;
    in_ch.switch_cause <= SC_OTHER;
    in_ch.point_index <= 4'd0;
    in_ch.point_current <= 16'd0;
    in_ch.point_duration <= 16'd0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= REG_RECOVERY;
    cfg_ch.data <= 16'd0;

    cfg_recovery = 16'd0;
    cfg_points = 5'd0;
    model_phase = PH_OPENED;
    model_cause = CA_EXT;
    model_retries = 16'd0;
    foreach (hold_cnt[i]) begin
      hold_cnt[i] = 16'd0;
      thr_tab[i] = 16'd0;
      dur_tab[i] = 16'd0;
    end
    armed = 1'b1;
    commit_due = 1'b1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_curve_trip();
    test_hw_overcurrent_retry();
    test_random_traffic();

    hold_until_drained();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("tb_breaker_trip_curve_controller_core OK");
    end else begin
      $display("tb_breaker_trip_curve_controller_core NOT OK");
    end
    $finish;
  end

endmodule
